// File: src/fcr_pkg.sv
// ----------------------------------------------------------------------------
// fcr_pkg - shared types and constants of the framed command receiver
// Register defaults, result codes, controller states and the setup-mode
// digit decode.
// ----------------------------------------------------------------------------
`default_nettype none

package fcr_pkg;

    localparam int FCR_FRAME_LEN   = 10;
    localparam int SETUP_DIGIT_POS = 8;

    localparam logic [7:0] START_BYTE_RST = 8'd126;
    localparam logic [7:0] STOP_BYTE_RST  = 8'd33;
    localparam logic [7:0] FWD_TYPE_RST   = 8'd0;
    localparam logic [7:0] SETUP_TYPE_RST = 8'd0;

    typedef enum logic [1:0] {
        CFG_START_BYTE = 2'd0,
        CFG_STOP_BYTE  = 2'd1,
        CFG_FWD_TYPE   = 2'd2,
        CFG_SETUP_TYPE = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        RK_FORWARD = 2'd0,
        RK_COMMAND = 2'd1,
        RK_REPORT  = 2'd2
    } t_result_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TYPE,
        S_DIGIT,
        S_REPLAY
    } t_state;

    // flag bits: ir, td, enc, pid, turn, token
    function automatic logic [5:0] decode_mode(input logic [7:0] digit);
        logic [5:0] flags;
        unique case (digit)
            "1", "3", "6": flags = 6'b110000;
            "2":           flags = 6'b001100;
            "4":           flags = 6'b101000;
            "5":           flags = 6'b110001;
            "7":           flags = 6'b110010;
            default:       flags = 6'b000000;
        endcase
        return flags;
    endfunction

endpackage

`default_nettype wire

// File: src/framed_command_receiver.sv
// ----------------------------------------------------------------------------
// framed_command_receiver - start/stop byte framing receiver
// Gathers bytes into a frame buffer RAM, checks the stop byte, replays
// forward frames, issues command words and reports frame counts.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) takes one word per item: a received byte
//   (i_kind=0) or a report tick (i_kind=1). Output channel (o_valid/i_ready)
//   gives result words; o_last marks the final word of one input item.
//   Config is a plain write port (i_cfg_we/i_cfg_index/i_cfg_data), to be
//   written by the user only while the block is idle; it does not enforce this.
// Sequencing:
//   Bytes that complete no good frame are handled in IDLE. A tick shows its
//   report word in the cycle after acceptance. A good command frame reads the
//   type byte (S_TYPE) and mode digit (S_DIGIT); S_DIGIT registers its word.
//   A forward frame reads the frame RAM one position per cycle in S_REPLAY
//   while the output is taken: FRAME_LEN words, the last the stop byte. Input
//   is taken again once the last word sits in the output register.
// Reset: counts, fill position and report number clear; config registers
//   return to defaults. The frame RAM is not cleared; every position whose
//   data reaches an output is written before it is read.
// Stall: a held output word blocks the controller; o_ready stays low until
//   the output register can take the next word.
// ----------------------------------------------------------------------------
`default_nettype none

module framed_command_receiver
    import fcr_pkg::*;
#(
    parameter int FRAME_LEN = FCR_FRAME_LEN
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    // input words
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_kind,
    input  wire logic [7:0]  i_rx_byte,
    // result words
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_result_kind,
    output logic [7:0]       o_frame_byte,
    output logic             o_last,
    output logic [7:0]       o_frame_type,
    output logic [5:0]       o_mode_flags,
    output logic [15:0]      o_good_count,
    output logic [15:0]      o_bad_count,
    output logic [7:0]       o_report_seq
);

    localparam int              POS_W     = $clog2(FRAME_LEN);
    localparam logic [POS_W-1:0] LAST_POS  = POS_W'(FRAME_LEN - 1);
    localparam logic [POS_W-1:0] TYPE_POS  = POS_W'(1);
    localparam logic [POS_W-1:0] DIGIT_POS = POS_W'(SETUP_DIGIT_POS);

    // config registers
    logic [7:0] r_start_byte, r_stop_byte, r_fwd_type, r_setup_type;

    // control state
    t_state           r_state, n_state;
    logic [POS_W-1:0] r_fill, n_fill;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [15:0]      r_good, n_good;
    logic [15:0]      r_bad, n_bad;
    logic [7:0]       r_seq, n_seq;
    logic [7:0]       r_type, n_type;
    logic             r_out_valid, n_out_valid;

    // output payload
    t_result_kind r_rk, n_rk;
    logic [7:0]   r_fb, n_fb;
    logic         r_last, n_last;
    logic [7:0]   r_ft, n_ft;
    logic [5:0]   r_mf, n_mf;
    logic [15:0]  r_gc, n_gc;
    logic [15:0]  r_bc, n_bc;
    logic [7:0]   r_rs, n_rs;

    // frame RAM
    logic             w_we;
    logic [POS_W-1:0] w_waddr;
    logic [7:0]       w_wdata;
    logic [POS_W-1:0] w_raddr;
    logic [7:0]       w_rdata;

    logic w_accept;
    logic w_out_free;

    fcr_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_LEN)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_out_free = !r_out_valid || i_ready;
    assign o_ready    = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_valid && o_ready;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_BYTE_RST;
            r_stop_byte  <= STOP_BYTE_RST;
            r_fwd_type   <= FWD_TYPE_RST;
            r_setup_type <= SETUP_TYPE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_START_BYTE: r_start_byte <= i_cfg_data;
                CFG_STOP_BYTE:  r_stop_byte  <= i_cfg_data;
                CFG_FWD_TYPE:   r_fwd_type   <= i_cfg_data;
                CFG_SETUP_TYPE: r_setup_type <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_pos       <= '0;
            r_good      <= '0;
            r_bad       <= '0;
            r_seq       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_pos       <= n_pos;
            r_good      <= n_good;
            r_bad       <= n_bad;
            r_seq       <= n_seq;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_type <= n_type;
        r_rk   <= n_rk;
        r_fb   <= n_fb;
        r_last <= n_last;
        r_ft   <= n_ft;
        r_mf   <= n_mf;
        r_gc   <= n_gc;
        r_bc   <= n_bc;
        r_rs   <= n_rs;
    end

    // controller: writes only in IDLE, uses read data only after a good stop byte,
    // so RAM accesses never overlap on one entry
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_pos       = r_pos;
        n_good      = r_good;
        n_bad       = r_bad;
        n_seq       = r_seq;
        n_type      = r_type;
        n_out_valid = r_out_valid && !i_ready;
        n_rk        = r_rk;
        n_fb        = r_fb;
        n_last      = r_last;
        n_ft        = r_ft;
        n_mf        = r_mf;
        n_gc        = r_gc;
        n_bc        = r_bc;
        n_rs        = r_rs;
        w_we        = 1'b0;
        w_waddr     = r_fill;
        w_wdata     = i_rx_byte;
        w_raddr     = TYPE_POS;

        unique case (r_state)
            S_IDLE: begin
                w_raddr = TYPE_POS;
                if (w_accept) begin
                    if (i_kind) begin
                        n_seq       = r_seq + 8'd1;
                        n_out_valid = 1'b1;
                        n_rk        = RK_REPORT;
                        n_fb        = '0;
                        n_last      = 1'b1;
                        n_ft        = '0;
                        n_mf        = '0;
                        n_gc        = r_good;
                        n_bc        = r_bad;
                        n_rs        = r_seq + 8'd1;
                        n_good      = '0;
                        n_bad       = '0;
                    end else if (i_rx_byte == r_start_byte) begin
                        w_we    = 1'b1;
                        w_waddr = '0;
                        n_fill  = POS_W'(1);
                    end else if (r_fill < LAST_POS) begin
                        w_we   = 1'b1;
                        n_fill = r_fill + 1'b1;
                    end else begin
                        n_fill = '0;
                        if (i_rx_byte != r_stop_byte) begin
                            n_bad = r_bad + 16'd1;
                        end else begin
                            // type byte read issued this cycle
                            n_good  = r_good + 16'd1;
                            n_state = S_TYPE;
                        end
                    end
                end
            end
            S_TYPE: begin
                n_type = w_rdata;
                if (w_rdata == r_fwd_type) begin
                    w_raddr = '0;
                    n_pos   = '0;
                    n_state = S_REPLAY;
                end else begin
                    w_raddr = DIGIT_POS;
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                w_raddr = DIGIT_POS;
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_rk        = RK_COMMAND;
                    n_fb        = '0;
                    n_last      = 1'b1;
                    n_ft        = r_type;
                    n_mf        = (r_type == r_setup_type) ? decode_mode(w_rdata) : 6'd0;
                    n_gc        = '0;
                    n_bc        = '0;
                    n_rs        = '0;
                    w_raddr     = TYPE_POS;
                    n_state     = S_IDLE;
                end
            end
            S_REPLAY: begin
                w_raddr = r_pos;
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_rk        = RK_FORWARD;
                    n_ft        = '0;
                    n_mf        = '0;
                    n_gc        = '0;
                    n_bc        = '0;
                    n_rs        = '0;
                    if (r_pos == LAST_POS) begin
                        n_fb    = r_stop_byte;
                        n_last  = 1'b1;
                        w_raddr = TYPE_POS;
                        n_state = S_IDLE;
                    end else begin
                        // next position read lines up with the next cycle
                        n_fb    = w_rdata;
                        n_last  = 1'b0;
                        n_pos   = r_pos + 1'b1;
                        w_raddr = r_pos + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid       = r_out_valid;
    assign o_result_kind = r_rk;
    assign o_frame_byte  = r_fb;
    assign o_last        = r_last;
    assign o_frame_type  = r_ft;
    assign o_mode_flags  = r_mf;
    assign o_good_count  = r_gc;
    assign o_bad_count   = r_bc;
    assign o_report_seq  = r_rs;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= LAST_POS)
        else $error("fill position beyond frame end");

    a_only_fwd_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (o_result_kind == RK_FORWARD))
        else $error("non-final word that is not a forwarded byte");

    a_tick_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_kind) |=> (o_valid && o_result_kind == RK_REPORT
                                  && r_good == 16'd0 && r_bad == 16'd0))
        else $error("tick did not produce report and clear counts");

    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready)
        else $error("input taken while frame is being read out");

endmodule

`default_nettype wire

// File: src/fcr_ram.sv
// ----------------------------------------------------------------------------
// fcr_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - testbench of the framed command receiver
// Streams received bytes and report ticks through the valid/ready input,
// keeps a cycle-free model of the frame state and counts, and compares every
// result word in order against it. Runs under several register settings,
// one stretch at full rate, and one setting where the forward and setup
// types are the same byte.
// ----------------------------------------------------------------------------

module tb_top
    import fcr_pkg::*;
();

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_WORDS = 56;

    typedef struct packed {
        t_result_kind kind;
        logic [7:0]   fbyte;
        logic         last;
        logic [7:0]   ftype;
        logic [5:0]   flags;
        logic [15:0]  good;
        logic [15:0]  bad;
        logic [7:0]   seq;
    } t_fcr_word;

    // flag bit positions in o_mode_flags
    localparam int FL_TOKEN = 0;
    localparam int FL_TURN  = 1;
    localparam int FL_PID   = 2;
    localparam int FL_ENC   = 3;
    localparam int FL_TD    = 4;
    localparam int FL_IR    = 5;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = CFG_START_BYTE;
    logic [7:0]  i_cfg_data = 8'h00;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_kind = 1'b0;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_result_kind;
    logic [7:0]  o_frame_byte;
    logic        o_last;
    logic [7:0]  o_frame_type;
    logic [5:0]  o_mode_flags;
    logic [15:0] o_good_count;
    logic [15:0] o_bad_count;
    logic [7:0]  o_report_seq;

    framed_command_receiver uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_rx_byte     (i_rx_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_result_kind (o_result_kind),
        .o_frame_byte  (o_frame_byte),
        .o_last        (o_last),
        .o_frame_type  (o_frame_type),
        .o_mode_flags  (o_mode_flags),
        .o_good_count  (o_good_count),
        .o_bad_count   (o_bad_count),
        .o_report_seq  (o_report_seq)
    );

    class frame_scoreboard;
        logic [7:0]  start_cfg;
        logic [7:0]  stop_cfg;
        logic [7:0]  fwd_cfg;
        logic [7:0]  setup_cfg;
        logic [7:0]  frame_buf [FCR_FRAME_LEN];
        logic [3:0]  fill;
        logic [15:0] good_frames;
        logic [15:0] bad_frames;
        logic [7:0]  report_num;
        t_fcr_word   due_words [$];
        int          errors;
        int          n_forward;
        int          n_command;
        int          n_setup;
        int          n_report;
        int          n_dropped;

        function new();
            start_cfg   = START_BYTE_RST;
            stop_cfg    = STOP_BYTE_RST;
            fwd_cfg     = FWD_TYPE_RST;
            setup_cfg   = SETUP_TYPE_RST;
            fill        = '0;
            good_frames = '0;
            bad_frames  = '0;
            report_num  = '0;
            errors      = 0;
            n_forward   = 0;
            n_command   = 0;
            n_setup     = 0;
            n_report    = 0;
            n_dropped   = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [7:0] val);
            case (idx)
                CFG_START_BYTE: start_cfg = val;
                CFG_STOP_BYTE:  stop_cfg  = val;
                CFG_FWD_TYPE:   fwd_cfg   = val;
                CFG_SETUP_TYPE: setup_cfg = val;
            endcase
        endfunction

        function logic [5:0] setup_flags(logic [7:0] digit);
            logic [5:0] f;
            f = '0;
            case (digit)
                "1", "3", "6": begin
                    f[FL_IR] = 1'b1;
                    f[FL_TD] = 1'b1;
                end
                "2": begin
                    f[FL_ENC] = 1'b1;
                    f[FL_PID] = 1'b1;
                end
                "4": begin
                    f[FL_IR]  = 1'b1;
                    f[FL_ENC] = 1'b1;
                end
                "5": begin
                    f[FL_IR]    = 1'b1;
                    f[FL_TD]    = 1'b1;
                    f[FL_TOKEN] = 1'b1;
                end
                "7": begin
                    f[FL_IR]   = 1'b1;
                    f[FL_TD]   = 1'b1;
                    f[FL_TURN] = 1'b1;
                end
                default: f = '0;
            endcase
            return f;
        endfunction

        // one accepted input word: advance the frame state, queue its results
        function void take_word(logic is_tick, logic [7:0] b);
            t_fcr_word w;
            w = '0;
            if (is_tick) begin
                report_num++;
                w.kind = RK_REPORT;
                w.last = 1'b1;
                w.good = good_frames;
                w.bad  = bad_frames;
                w.seq  = report_num;
                due_words.push_back(w);
                good_frames = '0;
                bad_frames  = '0;
                n_report++;
                return;
            end
            if (b == start_cfg) begin
                frame_buf[0] = b;
                fill = 4'd1;
                return;
            end
            if (fill < FCR_FRAME_LEN - 1) begin
                frame_buf[fill] = b;
                fill++;
                return;
            end
            fill = '0;
            if (b != stop_cfg) begin
                bad_frames++;
                n_dropped++;
                return;
            end
            good_frames++;
            if (frame_buf[1] == fwd_cfg) begin
                // replay ends on the stop byte itself
                for (int p = 0; p < FCR_FRAME_LEN; p++) begin
                    w       = '0;
                    w.kind  = RK_FORWARD;
                    w.last  = (p == FCR_FRAME_LEN - 1);
                    w.fbyte = w.last ? stop_cfg : frame_buf[p];
                    due_words.push_back(w);
                end
                n_forward++;
            end else begin
                w.kind  = RK_COMMAND;
                w.last  = 1'b1;
                w.ftype = frame_buf[1];
                if (frame_buf[1] == setup_cfg) begin
                    w.flags = setup_flags(frame_buf[SETUP_DIGIT_POS]);
                    n_setup++;
                end
                due_words.push_back(w);
                n_command++;
            end
        endfunction

        function void cmp(string name, logic [15:0] exp_v, logic [15:0] got_v);
            if (got_v !== exp_v) begin
                errors++;
                $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, got_v);
            end
        endfunction

        function void match_word(t_fcr_word got);
            t_fcr_word exp_w;
            if (due_words.size() == 0) begin
                errors++;
                $display("%0t: result word with nothing due: expected none, got %h", $time, got);
                return;
            end
            exp_w = due_words.pop_front();
            cmp("result_kind", 16'(exp_w.kind), 16'(got.kind));
            cmp("frame_byte", 16'(exp_w.fbyte), 16'(got.fbyte));
            cmp("last", 16'(exp_w.last), 16'(got.last));
            cmp("frame_type", 16'(exp_w.ftype), 16'(got.ftype));
            cmp("mode_flags", 16'(exp_w.flags), 16'(got.flags));
            cmp("good_count", exp_w.good, got.good);
            cmp("bad_count", exp_w.bad, got.bad);
            cmp("report_seq", 16'(exp_w.seq), 16'(got.seq));
        endfunction
    endclass

    frame_scoreboard board;
    bit              quiet = 1'b0;
    int              words_sent = 0;
    int              stall_cycles = 0;

    // start, type 0 (forward at reset), field extremes, stop
    localparam logic [7:0] FWD_SCRIPT [10] = '{
        8'h7E, 8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'h55, 8'hAA, 8'h00, 8'h21
    };
    // start, type, restart mid-frame, then a full command frame
    localparam logic [7:0] CMD_SCRIPT [12] = '{
        8'h7E, 8'h12, 8'h7E, 8'h12, 8'hFE, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05,
        "5", 8'h21
    };

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_ready <= quiet || ($urandom_range(0, 99) >= 7);
    end

    always @(posedge i_clk) begin : watch_results
        t_fcr_word got;
        if (i_rst_n && o_valid && i_ready) begin
            got.kind  = t_result_kind'(o_result_kind);
            got.fbyte = o_frame_byte;
            got.last  = o_last;
            got.ftype = o_frame_type;
            got.flags = o_mode_flags;
            got.good  = o_good_count;
            got.bad   = o_bad_count;
            got.seq   = o_report_seq;
            board.match_word(got);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("tb_top: FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_word(logic is_tick, logic [7:0] b);
        while (!quiet && $urandom_range(0, 99) < 7) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_kind    <= is_tick;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        board.take_word(is_tick, b);
        words_sent++;
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] v;
        do v = 8'($urandom_range(0, 255)); while (v == board.start_cfg);
        return v;
    endfunction

    function automatic logic [7:0] bad_tail();
        logic [7:0] v;
        do v = 8'($urandom_range(0, 255));
        while (v == board.stop_cfg || v == board.start_cfg);
        return v;
    endfunction

    task automatic send_frame();
        logic [7:0]  fr [FCR_FRAME_LEN];
        int unsigned roll;
        int unsigned cut;
        // without a start byte the frame fills on from the current fill position
        fr[0] = ($urandom_range(0, 99) < 90) ? board.start_cfg : plain_byte();
        roll = $urandom_range(0, 99);
        fr[1] = (roll < 30) ? board.fwd_cfg : (roll < 65) ? board.setup_cfg : plain_byte();
        for (int p = 2; p < FCR_FRAME_LEN - 1; p++) fr[p] = plain_byte();
        // '0'..'8' hits every decode arm and the no-flag default
        if ($urandom_range(0, 99) < 70)
            fr[SETUP_DIGIT_POS] = 8'h30 + 8'($urandom_range(0, 8));
        fr[FCR_FRAME_LEN - 1] = ($urandom_range(0, 99) < 85) ? board.stop_cfg : bad_tail();
        cut = ($urandom_range(0, 99) < 10) ? $urandom_range(1, FCR_FRAME_LEN - 1)
                                           : FCR_FRAME_LEN;
        for (int p = 0; p < cut; p++) send_word(1'b0, fr[p]);
    endtask

    task automatic run_phase(int n);
        int          base;
        int unsigned roll;
        base = words_sent;
        while (words_sent - base < n) begin
            roll = $urandom_range(0, 99);
            if (roll < 10)      send_word(1'b1, 8'($urandom_range(0, 255)));
            else if (roll < 16) send_word(1'b0, 8'($urandom_range(0, 255)));
            else                send_frame();
        end
    endtask

    // drain all due words, then give a frame-less byte time to retire
    task automatic settle();
        i_valid <= 1'b0;
        while (board.due_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic load_regs(logic [7:0] sb, logic [7:0] pb, logic [7:0] fb,
                             logic [7:0] ub);
        t_cfg_idx   regs [4];
        logic [7:0] vals [4];
        regs = '{CFG_START_BYTE, CFG_STOP_BYTE, CFG_FWD_TYPE, CFG_SETUP_TYPE};
        vals = '{sb, pb, fb, ub};
        foreach (regs[r]) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= regs[r];
            i_cfg_data  <= vals[r];
            @(posedge i_clk);
            board.set_reg(regs[r], vals[r]);
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [7:0] shared_type;
        board = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: start 7E, stop 21, forward and setup type 0
        send_word(1'b1, 8'hFF);
        foreach (FWD_SCRIPT[k]) send_word(1'b0, FWD_SCRIPT[k]);
        foreach (CMD_SCRIPT[k]) send_word(1'b0, CMD_SCRIPT[k]);
        send_word(1'b1, 8'h00);

        settle();
        load_regs(8'h00, 8'hFF, 8'hFF, 8'h5A);
        run_phase(PHASE_WORDS);

        settle();
        load_regs(8'hFF, 8'h00, 8'h3C, 8'h00);
        run_phase(PHASE_WORDS);

        settle();
        load_regs(8'h7E, 8'h21, 8'h00, 8'hFF);
        quiet = 1'b1;
        run_phase(PHASE_WORDS);
        quiet = 1'b0;

        settle();
        load_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        run_phase(PHASE_WORDS);

        // forward type shadows the setup type when both match
        settle();
        shared_type = 8'($urandom_range(0, 255));
        load_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  shared_type, shared_type);
        run_phase(PHASE_WORDS);

        settle();
        repeat (4) @(posedge i_clk);
        $display("tb_top: %0d input words, %0d forwarded frames, %0d commands (%0d setup)",
                 words_sent, board.n_forward, board.n_command, board.n_setup);
        $display("tb_top: %0d count reports, %0d dropped frames, %0d mismatches",
                 board.n_report, board.n_dropped, board.errors);
        if (board.errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

// File: framed_command_receiver.f
src/fcr_pkg.sv
src/fcr_ram.sv
src/framed_command_receiver.sv
verif/tb_top.sv
